/* rtl/imu_packet_parser_unwrap_unit_defines.svh */
// ----------------------------------------------------------------------------
// IMU packet parser assertion macros
// Shared concurrent assertion forms for the parser checkers.
// ----------------------------------------------------------------------------
`ifndef IMU_PACKET_PARSER_UNWRAP_UNIT_DEFINES_SVH
`define IMU_PACKET_PARSER_UNWRAP_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, disabled during reset.
`define IMUPP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("imupp: assertion failed");

// Next-cycle implication, sampled on clk_i, disabled during reset.
`define IMUPP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("imupp: assertion failed");

`endif

/* rtl/imupp_pkg.sv */
// ----------------------------------------------------------------------------
// IMU packet parser package
// Item types, frame constants and parser phase type.
// ----------------------------------------------------------------------------
package imupp_pkg;

  localparam int unsigned TURN_COUNT_WIDTH_DEFAULT = 16;

  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_ACC   = 8'h51;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;

  localparam logic [1:0] KIND_ANGLE = 2'd2;

  localparam logic [15:0] YAW_HIGH = 16'd49152;
  localparam logic [15:0] YAW_LOW  = 16'd16384;

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_TYPE,
    PH_DATA,
    PH_SUM
  } parse_phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       hold_off;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         packet_kind;
    logic [15:0]        word_x;
    logic [15:0]        word_y;
    logic [15:0]        word_z;
    logic [15:0]        temp_word;
    logic signed [15:0] yaw_turns;
    logic signed [31:0] yaw_unwrapped;
  } out_item_t;

endpackage

/* rtl/imupp_parser.sv */
// ----------------------------------------------------------------------------
// IMU packet parser core
// Frame state machine, checksum, payload store and yaw turn tracking.
// ----------------------------------------------------------------------------
module imupp_parser
  import imupp_pkg::*;
#(
  parameter int unsigned TURN_COUNT_WIDTH = TURN_COUNT_WIDTH_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  output logic      res_valid_o,
  output out_item_t res_o
);

  localparam logic signed [TURN_COUNT_WIDTH-1:0] TurnMax = {1'b0, {(TURN_COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [TURN_COUNT_WIDTH-1:0] TurnMin = {1'b1, {(TURN_COUNT_WIDTH-1){1'b0}}};
  localparam logic signed [TURN_COUNT_WIDTH-1:0] TurnOne = TURN_COUNT_WIDTH'(1);

  parse_phase_e phase_q, phase_d;
  logic [1:0]   kind_q, kind_d;
  logic [7:0]   sum_q, sum_d;
  logic [2:0]   idx_q, idx_d;
  logic [7:0]   payload_q [8];
  logic         payload_we;
  logic signed [TURN_COUNT_WIDTH-1:0] turn_q, turn_d;
  logic [15:0]  prev_yaw_q, prev_yaw_d;

  logic [15:0]        zraw;
  logic               wrap_up;
  logic               wrap_down;
  logic signed [32:0] turn_ext;
  logic signed [15:0] turn16;

  assign zraw      = {payload_q[5], payload_q[4]};
  assign wrap_up   = (prev_yaw_q > YAW_HIGH) && (zraw < YAW_LOW);
  assign wrap_down = (prev_yaw_q < YAW_LOW) && (zraw > YAW_HIGH);
  assign turn_ext  = 33'(turn_d);

  always_comb begin
    if (turn_ext > 33'sd32767) begin
      turn16 = 16'sh7fff;
    end else if (turn_ext < -33'sd32768) begin
      turn16 = 16'sh8000;
    end else begin
      turn16 = turn_ext[15:0];
    end
  end

  always_comb begin
    phase_d     = phase_q;
    kind_d      = kind_q;
    sum_d       = sum_q;
    idx_d       = idx_q;
    turn_d      = turn_q;
    prev_yaw_d  = prev_yaw_q;
    payload_we  = 1'b0;
    res_valid_o = 1'b0;
    if (step_i) begin
      case (phase_q)
        PH_SEARCH: begin
          if (!item_i.hold_off && item_i.data_byte == HDR_BYTE) begin
            sum_d   = HDR_BYTE;
            phase_d = PH_TYPE;
          end
        end
        PH_TYPE: begin
          if (item_i.data_byte >= TYPE_ACC && item_i.data_byte <= TYPE_ANGLE) begin
            kind_d  = 2'(item_i.data_byte - TYPE_ACC);
            sum_d   = sum_q + item_i.data_byte;
            idx_d   = '0;
            phase_d = PH_DATA;
          end else begin
            phase_d = PH_SEARCH;
          end
        end
        PH_DATA: begin
          payload_we = 1'b1;
          sum_d      = sum_q + item_i.data_byte;
          idx_d      = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            phase_d = PH_SUM;
          end
        end
        PH_SUM: begin
          phase_d = PH_SEARCH;
          idx_d   = '0;
          if (item_i.data_byte == sum_q) begin
            res_valid_o = 1'b1;
            if (kind_q == KIND_ANGLE) begin
              if (wrap_up && turn_q != TurnMax) begin
                turn_d = turn_q + TurnOne;
              end else if (wrap_down && turn_q != TurnMin) begin
                turn_d = turn_q - TurnOne;
              end
              prev_yaw_d = zraw;
            end
          end
        end
        default: begin
          phase_d = PH_SEARCH;
        end
      endcase
    end
  end

  always_comb begin
    res_o.packet_kind   = kind_q;
    res_o.word_x        = {payload_q[1], payload_q[0]};
    res_o.word_y        = {payload_q[3], payload_q[2]};
    res_o.word_z        = zraw;
    res_o.temp_word     = {payload_q[7], payload_q[6]};
    res_o.yaw_turns     = turn16;
    res_o.yaw_unwrapped = {turn16, prev_yaw_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SEARCH;
      kind_q     <= '0;
      sum_q      <= '0;
      idx_q      <= '0;
      turn_q     <= '0;
      prev_yaw_q <= '0;
    end else begin
      phase_q    <= phase_d;
      kind_q     <= kind_d;
      sum_q      <= sum_d;
      idx_q      <= idx_d;
      turn_q     <= turn_d;
      prev_yaw_q <= prev_yaw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (payload_we) begin
      payload_q[idx_q] <= item_i.data_byte;
    end
  end

endmodule

/* rtl/imu_packet_parser_unwrap_unit.sv */
// Output: a result item is registered as the parser consumes the checksum byte.
// Throughput: one byte per cycle while the output is not stalled, set by the
// single-pass parser between the input register and the result register.
// Reset: asynchronous, active low; clears the parse phase, checksum, turn count,
// last yaw and both valid flags.
// ----------------------------------------------------------------------------
// IMU packet parser with yaw unwrapping
// Takes serial bytes and emits one item per frame with a matching checksum.
// ----------------------------------------------------------------------------
module imu_packet_parser_unwrap_unit
  import imupp_pkg::*;
#(
  parameter int unsigned TURN_COUNT_WIDTH = TURN_COUNT_WIDTH_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;

  logic      advance;
  logic      res_valid;
  out_item_t res;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;

  imupp_parser #(
    .TURN_COUNT_WIDTH(TURN_COUNT_WIDTH)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (in_valid_q && advance),
    .item_i     (in_item_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
    if (advance && res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* rtl/imupp_checker.sv */
// ----------------------------------------------------------------------------
// IMU packet parser checker
// Port-level assertions on the parser top level, attached by bind.
// ----------------------------------------------------------------------------
`include "imu_packet_parser_unwrap_unit_defines.svh"

module imupp_checker
  import imupp_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  `IMUPP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o))
  `IMUPP_ASSERT_NOW(a_ready_when_empty, !out_valid_o, in_ready_o)
  `IMUPP_ASSERT_NOW(a_kind_range, out_valid_o, out_item_o.packet_kind != 2'd3)
  `IMUPP_ASSERT_NOW(a_unwrap_turns, out_valid_o, out_item_o.yaw_unwrapped[31:16] == out_item_o.yaw_turns)

endmodule

bind imu_packet_parser_unwrap_unit imupp_checker u_checker (.*);
